// ===== rtl/cpr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the complex plane remap
// Mode codes, fixed-point constants, the pipeline side-band word and saturating helpers.
// ----------------------------------------------------------------------------
package cpr_pkg;

   typedef enum logic [2:0] {
      MODE_IDENT   = 3'd0,
      MODE_INV     = 3'd1,
      MODE_INV_Q   = 3'd2,
      MODE_LAM     = 3'd3,
      MODE_INV_LAM = 3'd4,
      MODE_INV_L1  = 3'd5,
      MODE_INV_F   = 3'd6,
      MODE_IDENT2  = 3'd7
   } mode_type;

   localparam logic [63:0] NEAR_LIMIT = 64'd4295;
   localparam logic [63:0] QUARTER    = 64'h0000_0000_4000_0000;
   localparam logic [63:0] ONE_Q      = 64'h0000_0001_0000_0000;
   localparam logic [63:0] FEIG_NEG   = 64'hFFFF_FFFE_994E_3BCD;
   localparam logic [63:0] SENTINEL   = 64'h7FFF_FFFF_0000_0000;
   localparam logic [63:0] SMAX       = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SMIN       = 64'h8000_0000_0000_0000;

   localparam int DIV_STEPS  = 128;
   localparam int DIV_PER_ST = 4;
   localparam int DIV_STAGES = DIV_STEPS / DIV_PER_ST;

   typedef struct packed {
      mode_type    mode;
      logic        pole;
      logic        sat;
      logic        neg_re;
      logic        neg_im;
   } side_type;

   function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b,
                                           output logic flag);
      logic [63:0] s;
      s = a + b;
      flag = (((a ^ s) & (b ^ s)) >> 63) != 64'd0;
      if (flag) return a[63] ? SMIN : SMAX;
      return s;
   endfunction

   function automatic logic [63:0] sat_mag(input logic [127:0] q, input logic negative,
                                           output logic flag);
      if (negative) begin
         flag = (q[127:64] != 64'd0) || (q[63:0] > SMIN);
         return flag ? SMIN : (64'd0 - q[63:0]);
      end
      flag = (q[127:64] != 64'd0) || (q[63:0] > SMAX);
      return flag ? SMAX : q[63:0];
   endfunction

   function automatic logic [63:0] sat128(input logic [127:0] a, output logic flag);
      flag = a[127:63] != {65{a[63]}};
      if (flag) return a[127] ? SMIN : SMAX;
      return a[63:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cpr_recip.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cpr_recip: pipelined complex reciprocal
// |z|^2 by split multiplies, then two restoring dividers at DIV_PER_ST quotient bits a stage.
// ----------------------------------------------------------------------------
module cpr_recip (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [63:0]         in_re,
   input  wire logic [63:0]         in_im,
   input  wire cpr_pkg::side_type   in_side,
   output logic                     out_valid,
   output logic [63:0]              out_re,
   output logic [63:0]              out_im,
   output logic [63:0]              out_x,
   output logic [63:0]              out_y,
   output logic                     out_zero,
   output cpr_pkg::side_type        out_side
);
   localparam int NS = cpr_pkg::DIV_STAGES;
   localparam int PS = cpr_pkg::DIV_PER_ST;

   // stage A: magnitudes and 32x32 partial products
   logic              a_v_ff;
   logic [63:0]       a_mx_ff, a_my_ff, a_x_ff, a_y_ff;
   logic [63:0]       a_p_ff [8];
   cpr_pkg::side_type a_s_ff;
   logic [63:0]       mx_in, my_in;

   // stage B: |z|^2
   logic              b_v_ff;
   logic [63:0]       b_mx_ff, b_my_ff, b_x_ff, b_y_ff;
   logic [127:0]      b_d_ff;
   cpr_pkg::side_type b_s_ff;
   logic [127:0]      sq_x, sq_y;

   // divider stages
   logic              d_v_ff  [NS];
   logic [127:0]      d_rx_ff [NS], d_ry_ff [NS], d_qx_ff [NS], d_qy_ff [NS];
   logic [127:0]      d_nx_ff [NS], d_ny_ff [NS], d_d_ff [NS];
   logic [63:0]       d_x_ff  [NS], d_y_ff [NS];
   cpr_pkg::side_type d_s_ff  [NS];

   logic              o_v_ff, o_z_ff;
   logic [63:0]       o_re_ff, o_im_ff, o_x_ff, o_y_ff;
   cpr_pkg::side_type o_s_ff;

   assign mx_in = in_re[63] ? 64'd0 - in_re : in_re;
   assign my_in = in_im[63] ? 64'd0 - in_im : in_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
      end
      if (en) begin
         a_mx_ff <= mx_in;
         a_my_ff <= my_in;
         a_x_ff  <= in_re;
         a_y_ff  <= in_im;
         a_s_ff  <= in_side;
         a_p_ff[0] <= mx_in[31:0] * mx_in[31:0];
         a_p_ff[1] <= mx_in[31:0] * mx_in[63:32];
         a_p_ff[2] <= mx_in[63:32] * mx_in[63:32];
         a_p_ff[3] <= my_in[31:0] * my_in[31:0];
         a_p_ff[4] <= my_in[31:0] * my_in[63:32];
         a_p_ff[5] <= my_in[63:32] * my_in[63:32];
         a_p_ff[6] <= 64'd0;
         a_p_ff[7] <= 64'd0;
      end
   end

   assign sq_x = {a_p_ff[2], 64'd0} + ({64'd0, a_p_ff[1]} << 33) + {64'd0, a_p_ff[0]};
   assign sq_y = {a_p_ff[5], 64'd0} + ({64'd0, a_p_ff[4]} << 33) + {64'd0, a_p_ff[3]}
               + {a_p_ff[6], a_p_ff[7]};

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
      if (en) begin
         b_d_ff  <= sq_x + sq_y;
         b_mx_ff <= a_mx_ff;
         b_my_ff <= a_my_ff;
         b_x_ff  <= a_x_ff;
         b_y_ff  <= a_y_ff;
         b_s_ff  <= a_s_ff;
      end
   end

   for (genvar g = 0; g < NS; g++) begin : g_div
      logic [127:0] rx_c, ry_c, qx_c, qy_c, nx_c, ny_c, dd;
      logic         v_c;
      logic [63:0]  x_c, y_c;
      cpr_pkg::side_type s_c;
      if (g == 0) begin : g_first
         assign rx_c = 128'd0;
         assign ry_c = 128'd0;
         assign qx_c = 128'd0;
         assign qy_c = 128'd0;
         assign nx_c = {b_mx_ff, 64'd0};
         assign ny_c = {b_my_ff, 64'd0};
         assign dd   = b_d_ff;
         assign v_c  = b_v_ff;
         assign x_c  = b_x_ff;
         assign y_c  = b_y_ff;
         assign s_c  = b_s_ff;
      end else begin : g_next
         assign rx_c = d_rx_ff[g-1];
         assign ry_c = d_ry_ff[g-1];
         assign qx_c = d_qx_ff[g-1];
         assign qy_c = d_qy_ff[g-1];
         assign nx_c = d_nx_ff[g-1];
         assign ny_c = d_ny_ff[g-1];
         assign dd   = d_d_ff[g-1];
         assign v_c  = d_v_ff[g-1];
         assign x_c  = d_x_ff[g-1];
         assign y_c  = d_y_ff[g-1];
         assign s_c  = d_s_ff[g-1];
      end

      logic [127:0] rx_in, ry_in, qx_in, qy_in, nx_in, ny_in;
      always_comb begin
         logic [128:0] tx, ty;
         rx_in = rx_c;
         ry_in = ry_c;
         qx_in = qx_c;
         qy_in = qy_c;
         nx_in = nx_c;
         ny_in = ny_c;
         for (int k = 0; k < PS; k++) begin
            tx = {rx_in, nx_in[127]};
            ty = {ry_in, ny_in[127]};
            nx_in = nx_in << 1;
            ny_in = ny_in << 1;
            qx_in = qx_in << 1;
            qy_in = qy_in << 1;
            if (tx >= {1'b0, dd}) begin
               tx = tx - {1'b0, dd};
               qx_in[0] = 1'b1;
            end
            if (ty >= {1'b0, dd}) begin
               ty = ty - {1'b0, dd};
               qy_in[0] = 1'b1;
            end
            rx_in = tx[127:0];
            ry_in = ty[127:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_v_ff[g] <= 1'b0;
         end else if (en) begin
            d_v_ff[g] <= v_c;
         end
         if (en) begin
            d_rx_ff[g] <= rx_in;
            d_ry_ff[g] <= ry_in;
            d_qx_ff[g] <= qx_in;
            d_qy_ff[g] <= qy_in;
            d_nx_ff[g] <= nx_in;
            d_ny_ff[g] <= ny_in;
            d_d_ff[g]  <= dd;
            d_x_ff[g]  <= x_c;
            d_y_ff[g]  <= y_c;
            d_s_ff[g]  <= s_c;
         end
      end
   end

   logic [63:0]       re_c, im_c;
   logic              fr, fi, negx, negy;
   cpr_pkg::side_type o_s_in;
   always_comb begin
      negx = d_x_ff[NS-1][63] && (d_x_ff[NS-1] != 64'd0);
      negy = !d_y_ff[NS-1][63] && (d_y_ff[NS-1] != 64'd0);
      re_c = cpr_pkg::sat_mag(d_qx_ff[NS-1], negx, fr);
      im_c = cpr_pkg::sat_mag(d_qy_ff[NS-1], negy, fi);
      o_s_in = d_s_ff[NS-1];
      o_s_in.sat = d_s_ff[NS-1].sat | fr | fi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_v_ff <= 1'b0;
      end else if (en) begin
         o_v_ff <= d_v_ff[NS-1];
      end
      if (en) begin
         o_re_ff <= re_c;
         o_im_ff <= im_c;
         o_x_ff  <= d_x_ff[NS-1];
         o_y_ff  <= d_y_ff[NS-1];
         o_z_ff  <= d_d_ff[NS-1] == 128'd0;
         o_s_ff  <= o_s_in;
      end
   end

   assign out_valid = o_v_ff;
   assign out_re    = o_re_ff;
   assign out_im    = o_im_ff;
   assign out_x     = o_x_ff;
   assign out_y     = o_y_ff;
   assign out_zero  = o_z_ff;
   assign out_side  = o_s_ff;

endmodule

`default_nettype wire

// ===== rtl/complex_plane_remap.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 40 register stages (2 square, 32 divide, 1 clamp, 1 offset,
//   3 lambda multiply/sum, 1 select and output register).
// Throughput: one item per cycle; the whole pipeline advances when the output
//   register is empty or its result is taken.
// Reset: synchronous; clears all stage valid bits and sets mode_ff to 0.
// ----------------------------------------------------------------------------
// complex_plane_remap: per-coordinate plane mapping in Q32.32
// Reciprocal, offset and lambda stages in one stall-together pipeline.
// ----------------------------------------------------------------------------
module complex_plane_remap (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_data,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [127:0]  req_tdata,   // re_in[63:0], im_in[127:64]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [127:0]       rsp_tdata,   // re_out[63:0], im_out[127:64]
   output logic [1:0]         rsp_tuser    // saturated[0], near_pole[1]
);
   logic [2:0] mode_ff;
   logic       en;
   logic       out_v_ff;
   logic [127:0] out_d_ff;
   logic [1:0]   out_u_ff;

   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 3'd0;
      end else if (csr_valid) begin
         mode_ff <= csr_data;
      end
   end

   cpr_pkg::side_type side_in;
   always_comb begin
      side_in        = '0;
      side_in.mode   = cpr_pkg::mode_type'(mode_ff);
   end

   logic              r_v, r_z;
   logic [63:0]       r_re, r_im, r_x, r_y;
   cpr_pkg::side_type r_s;

   cpr_recip u_recip (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_re     (req_tdata[63:0]),
      .in_im     (req_tdata[127:64]),
      .in_side   (side_in),
      .out_valid (r_v),
      .out_re    (r_re),
      .out_im    (r_im),
      .out_x     (r_x),
      .out_y     (r_y),
      .out_zero  (r_z),
      .out_side  (r_s)
   );

   // offset stage: pick lambda operand and offsets
   logic              e_v_ff;
   logic [63:0]       e_a_ff, e_b_ff, e_x_ff, e_y_ff, e_rre_ff, e_rim_ff;
   cpr_pkg::side_type e_s_ff;
   logic [63:0]       a_c, rre_c, off_c;
   logic              fa, fo, pole_c, near_c;
   logic [63:0]       mx, my;
   logic [63:0]       e_a_in, e_b_in;
   cpr_pkg::side_type e_s_in;

   always_comb begin
      mx = r_x[63] ? 64'd0 - r_x : r_x;
      my = r_y[63] ? 64'd0 - r_y : r_y;
      near_c = (mx < cpr_pkg::NEAR_LIMIT) && (my < cpr_pkg::NEAR_LIMIT)
            && ((mx + my) < cpr_pkg::NEAR_LIMIT);
      case (r_s.mode)
         cpr_pkg::MODE_INV_Q: off_c = cpr_pkg::QUARTER;
         cpr_pkg::MODE_INV_F: off_c = cpr_pkg::FEIG_NEG;
         default:             off_c = 64'd0;
      endcase
      rre_c  = cpr_pkg::add_sat(r_re, off_c, fo);
      a_c    = cpr_pkg::add_sat(r_re, cpr_pkg::ONE_Q, fa);
      pole_c = 1'b0;
      unique case (r_s.mode)
         cpr_pkg::MODE_INV, cpr_pkg::MODE_INV_Q, cpr_pkg::MODE_INV_F: pole_c = near_c;
         cpr_pkg::MODE_INV_LAM, cpr_pkg::MODE_INV_L1: pole_c = r_z;
         default: pole_c = 1'b0;
      endcase
      e_s_in      = r_s;
      e_s_in.pole = pole_c;
      e_a_in      = r_re;
      e_b_in      = r_im;
      unique case (r_s.mode)
         cpr_pkg::MODE_LAM: begin
            e_a_in = r_x;
            e_b_in = r_y;
            e_s_in.sat = 1'b0;
         end
         cpr_pkg::MODE_INV_L1: begin
            e_a_in = a_c;
            e_s_in.sat = r_s.sat | fa;
         end
         cpr_pkg::MODE_INV_LAM: begin
            e_a_in = r_re;
         end
         default: begin
            e_s_in.sat = r_s.sat | fo;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= r_v;
      end
      if (en) begin
         e_x_ff   <= r_x;
         e_y_ff   <= r_y;
         e_rre_ff <= rre_c;
         e_rim_ff <= r_im;
         e_s_ff   <= e_s_in;
         e_a_ff   <= e_a_in;
         e_b_ff   <= e_b_in;
      end
   end

   // lambda: partial products of magnitudes
   logic              m_v_ff;
   logic [63:0]       m_a_ff, m_b_ff, m_x_ff, m_y_ff, m_rre_ff, m_rim_ff;
   cpr_pkg::side_type m_s_ff;
   logic [63:0]       m_p_ff [12];
   logic              m_na_ff, m_nb_ff;
   logic [63:0]       ma, mb;
   assign ma = e_a_ff[63] ? 64'd0 - e_a_ff : e_a_ff;
   assign mb = e_b_ff[63] ? 64'd0 - e_b_ff : e_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= e_v_ff;
      end
      if (en) begin
         m_a_ff <= e_a_ff;
         m_b_ff <= e_b_ff;
         m_x_ff <= e_x_ff;
         m_y_ff <= e_y_ff;
         m_rre_ff <= e_rre_ff;
         m_rim_ff <= e_rim_ff;
         m_s_ff <= e_s_ff;
         m_na_ff <= e_a_ff[63];
         m_nb_ff <= e_b_ff[63];
         m_p_ff[0]  <= ma[31:0]  * ma[31:0];
         m_p_ff[1]  <= ma[31:0]  * ma[63:32];
         m_p_ff[2]  <= ma[63:32] * ma[63:32];
         m_p_ff[3]  <= mb[31:0]  * mb[31:0];
         m_p_ff[4]  <= mb[31:0]  * mb[63:32];
         m_p_ff[5]  <= mb[63:32] * mb[63:32];
         m_p_ff[6]  <= ma[31:0]  * mb[31:0];
         m_p_ff[7]  <= ma[31:0]  * mb[63:32];
         m_p_ff[8]  <= ma[63:32] * mb[31:0];
         m_p_ff[9]  <= ma[63:32] * mb[63:32];
         m_p_ff[10] <= 64'd0;
         m_p_ff[11] <= 64'd0;
      end
   end

   // lambda: products assembled
   logic              n_v_ff;
   logic [63:0]       n_a_ff, n_b_ff, n_x_ff, n_y_ff, n_rre_ff, n_rim_ff;
   cpr_pkg::side_type n_s_ff;
   logic [127:0]      n_aa_ff, n_bb_ff, n_ab_ff;
   logic [127:0]      ab_u;
   assign ab_u = {m_p_ff[9], 64'd0} + ({64'd0, m_p_ff[7]} << 32)
               + ({64'd0, m_p_ff[8]} << 32) + {64'd0, m_p_ff[6]};

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
      end else if (en) begin
         n_v_ff <= m_v_ff;
      end
      if (en) begin
         n_a_ff <= m_a_ff;
         n_b_ff <= m_b_ff;
         n_x_ff <= m_x_ff;
         n_y_ff <= m_y_ff;
         n_rre_ff <= m_rre_ff;
         n_rim_ff <= m_rim_ff;
         n_s_ff <= m_s_ff;
         n_aa_ff <= {m_p_ff[2], 64'd0} + ({64'd0, m_p_ff[1]} << 33) + {64'd0, m_p_ff[0]}
                  + {m_p_ff[10], m_p_ff[11]};
         n_bb_ff <= {m_p_ff[5], 64'd0} + ({64'd0, m_p_ff[4]} << 33) + {64'd0, m_p_ff[3]};
         n_ab_ff <= (m_na_ff ^ m_nb_ff) ? 128'd0 - ab_u : ab_u;
      end
   end

   // lambda: sums, shift and clamp
   logic              l_v_ff;
   logic [63:0]       l_re_ff, l_im_ff, l_x_ff, l_y_ff, l_rre_ff, l_rim_ff;
   cpr_pkg::side_type l_s_ff;
   logic [127:0]      t_c, u_c, ts_c, us_c;
   logic [63:0]       lre_c, lim_c;
   logic              ft, fu;
   cpr_pkg::side_type l_s_in;
   always_comb begin
      t_c  = ({{64{n_a_ff[63]}}, n_a_ff} << 33) - (n_aa_ff - n_bb_ff);
      u_c  = ({{64{n_b_ff[63]}}, n_b_ff} << 32) - n_ab_ff;
      ts_c = $signed(t_c) >>> 34;
      us_c = $signed(u_c) >>> 33;
      lre_c = cpr_pkg::sat128(ts_c, ft);
      lim_c = cpr_pkg::sat128(us_c, fu);
      l_s_in = n_s_ff;
      l_s_in.neg_re = ft | fu;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l_v_ff <= 1'b0;
      end else if (en) begin
         l_v_ff <= n_v_ff;
      end
      if (en) begin
         l_re_ff  <= lre_c;
         l_im_ff  <= lim_c;
         l_x_ff   <= n_x_ff;
         l_y_ff   <= n_y_ff;
         l_rre_ff <= n_rre_ff;
         l_rim_ff <= n_rim_ff;
         l_s_ff   <= l_s_in;
      end
   end

   // final select
   logic [127:0] sel_d;
   logic [1:0]   sel_u;
   always_comb begin
      sel_d = {l_y_ff, l_x_ff};
      sel_u = 2'b00;
      unique case (l_s_ff.mode)
         cpr_pkg::MODE_INV, cpr_pkg::MODE_INV_Q, cpr_pkg::MODE_INV_F: begin
            if (l_s_ff.pole) begin
               sel_d = {cpr_pkg::SENTINEL, l_rre_ff};
               sel_d[63:0] = cpr_pkg::SENTINEL + (l_s_ff.mode == cpr_pkg::MODE_INV_Q ?
                  cpr_pkg::QUARTER : l_s_ff.mode == cpr_pkg::MODE_INV_F ?
                  cpr_pkg::FEIG_NEG : 64'd0);
               sel_u = 2'b10;
            end else begin
               sel_d = {l_rim_ff, l_rre_ff};
               sel_u = {1'b0, l_s_ff.sat};
            end
         end
         cpr_pkg::MODE_LAM, cpr_pkg::MODE_INV_LAM, cpr_pkg::MODE_INV_L1: begin
            if (l_s_ff.pole) begin
               sel_d = {cpr_pkg::SENTINEL, cpr_pkg::SENTINEL};
               sel_u = 2'b10;
            end else begin
               sel_d = {l_im_ff, l_re_ff};
               sel_u = {1'b0, l_s_ff.sat | l_s_ff.neg_re};
            end
         end
         default: begin
            sel_d = {l_y_ff, l_x_ff};
            sel_u = 2'b00;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= l_v_ff;
      end
      if (en) begin
         out_d_ff <= sel_d;
         out_u_ff <= sel_u;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_u_ff;

   ap_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result lost under stall");
   ap_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && rsp_tuser[1]))
      else $error("pole and saturation both set");
   ap_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");

endmodule

`default_nettype wire
